// File: rtl/spds_pkg.sv
// shared types, constants and stencil coefficients of the six-point derivative core
`timescale 1ns / 1ps
`default_nettype none

package spds_pkg;

    localparam int WINDOW_LEN   = 6;
    localparam int COEF_W       = 12;
    localparam int SCALE_W      = 48;
    localparam int CHUNK_W      = 12;
    localparam int FRAC_BITS    = 24;
    localparam int OUT_W        = 32;
    localparam int POINT_W      = 16;
    localparam int STATUS_W     = 2;
    localparam int ORDER_W      = 3;
    localparam int ROW_W        = 3;
    localparam int CFG_IDX_W    = 1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LONG  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_ORDER  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE = 1'b1;

    // stencil rows
    localparam logic [ROW_W-1:0] ROW_FIRST  = 3'd0;
    localparam logic [ROW_W-1:0] ROW_CENTRE = 3'd2;
    localparam logic [ROW_W-1:0] ROW_LAST   = 3'd5;

    typedef enum logic {
        ST_IDLE,
        ST_ISSUE
    } spds_state_t;

    typedef struct packed {
        logic                valid;
        logic [POINT_W-1:0]  point;
        logic [STATUS_W-1:0] status;
        logic                last;
    } spds_meta_t;

    typedef struct packed {
        spds_meta_t          meta;
        logic [ROW_W-1:0]    row;
    } spds_issue_t;

    // integer stencils, [order-1][row][window position]
    localparam logic signed [COEF_W-1:0] COEF_TABLE [5][6][6] = '{
        '{
            '{-12'sd274,  12'sd600, -12'sd600,  12'sd400, -12'sd150,  12'sd24},
            '{-12'sd24,  -12'sd130,  12'sd240, -12'sd120,  12'sd40,  -12'sd6},
            '{ 12'sd6,   -12'sd60,  -12'sd40,   12'sd120, -12'sd30,   12'sd4},
            '{-12'sd4,    12'sd30,  -12'sd120,  12'sd40,   12'sd60,  -12'sd6},
            '{ 12'sd6,   -12'sd40,   12'sd120, -12'sd240,  12'sd130,  12'sd24},
            '{-12'sd24,   12'sd150, -12'sd400,  12'sd600, -12'sd600,  12'sd274}
        },
        '{
            '{ 12'sd225, -12'sd770,  12'sd1070, -12'sd780, 12'sd305, -12'sd50},
            '{ 12'sd50,  -12'sd75,  -12'sd20,    12'sd70, -12'sd30,   12'sd5},
            '{-12'sd5,    12'sd80,  -12'sd150,   12'sd80, -12'sd5,    12'sd0},
            '{ 12'sd0,   -12'sd5,    12'sd80,  -12'sd150,  12'sd80,  -12'sd5},
            '{ 12'sd5,   -12'sd30,   12'sd70,  -12'sd20,  -12'sd75,   12'sd50},
            '{-12'sd50,   12'sd305, -12'sd780,  12'sd1070, -12'sd770, 12'sd225}
        },
        '{
            '{-12'sd85,   12'sd355, -12'sd590,  12'sd490, -12'sd205,  12'sd35},
            '{-12'sd35,   12'sd125, -12'sd170,  12'sd110, -12'sd35,   12'sd5},
            '{-12'sd5,   -12'sd5,    12'sd50,  -12'sd70,   12'sd35,  -12'sd5},
            '{ 12'sd5,   -12'sd35,   12'sd70,  -12'sd50,   12'sd5,    12'sd5},
            '{-12'sd5,    12'sd35,  -12'sd110,  12'sd170, -12'sd125,  12'sd35},
            '{-12'sd35,   12'sd205, -12'sd490,  12'sd590, -12'sd355,  12'sd85}
        },
        '{
            '{ 12'sd15,  -12'sd70,   12'sd130, -12'sd120,  12'sd55,  -12'sd10},
            '{ 12'sd10,  -12'sd45,   12'sd80,  -12'sd70,   12'sd30,  -12'sd5},
            '{ 12'sd5,   -12'sd20,   12'sd30,  -12'sd20,   12'sd5,    12'sd0},
            '{ 12'sd0,    12'sd5,   -12'sd20,   12'sd30,  -12'sd20,   12'sd5},
            '{-12'sd5,    12'sd30,  -12'sd70,   12'sd80,  -12'sd45,   12'sd10},
            '{-12'sd10,   12'sd55,  -12'sd120,  12'sd130, -12'sd70,   12'sd15}
        },
        '{
            '{-12'sd1, 12'sd5, -12'sd10, 12'sd10, -12'sd5, 12'sd1},
            '{-12'sd1, 12'sd5, -12'sd10, 12'sd10, -12'sd5, 12'sd1},
            '{-12'sd1, 12'sd5, -12'sd10, 12'sd10, -12'sd5, 12'sd1},
            '{-12'sd1, 12'sd5, -12'sd10, 12'sd10, -12'sd5, 12'sd1},
            '{-12'sd1, 12'sd5, -12'sd10, 12'sd10, -12'sd5, 12'sd1},
            '{-12'sd1, 12'sd5, -12'sd10, 12'sd10, -12'sd5, 12'sd1}
        }
    };

    // order 0 acts as first order, 6 and 7 as fifth
    function automatic logic signed [COEF_W-1:0] spds_coef(
        input logic [ORDER_W-1:0] order,
        input logic [ROW_W-1:0]   row,
        input logic [ROW_W-1:0]   pos
    );
        logic [ORDER_W-1:0] ord_idx;
        logic signed [COEF_W-1:0] coef;
        if (order == 3'd0) begin
            ord_idx = 3'd0;
        end
        else if (order > 3'd5) begin
            ord_idx = 3'd4;
        end
        else begin
            ord_idx = order - 3'd1;
        end
        if ((row > ROW_LAST) || (pos > ROW_LAST)) begin
            coef = '0;
        end
        else begin
            coef = COEF_TABLE[ord_idx][row][pos];
        end
        return coef;
    endfunction

endpackage

`default_nettype wire

// File: rtl/spds_cell.sv
// one window cell: holds a sample, hands it to its neighbour and weights it by its coefficient
`timescale 1ns / 1ps
`default_nettype none

module spds_cell #(
    parameter int SW  = 32,
    parameter int POS = 0
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      shift_en,
    input  logic signed [SW-1:0]                      sample_in,
    output logic signed [SW-1:0]                      sample_out,
    input  logic                                      adv,
    input  logic [spds_pkg::ORDER_W-1:0]              order,
    input  logic [spds_pkg::ROW_W-1:0]                row,
    output logic signed [SW+spds_pkg::COEF_W-1:0]     prod
);
    import spds_pkg::*;

    logic signed [SW-1:0]        sample_reg;
    logic signed [SW-1:0]        sample_next;
    logic signed [SW+COEF_W-1:0] prod_reg;
    logic signed [SW+COEF_W-1:0] prod_next;
    logic signed [COEF_W-1:0]    coef;

    assign coef = spds_coef(order, row, ROW_W'(POS));

    always_comb
    begin
        sample_next = shift_en ? sample_in : sample_reg;
        prod_next   = adv ? (sample_reg * coef) : prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign sample_out = sample_reg;
    assign prod       = prod_reg;

endmodule

`default_nettype wire

// File: rtl/spds_ctrl.sv
// sample counter and issue sequencer of the derivative core
`timescale 1ns / 1ps
`default_nettype none

module spds_ctrl #(
    parameter int MAX_POINTS = 65536
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  final_sample,
    input  logic                  adv,
    output logic                  in_ready,
    output logic                  shift_en,
    output spds_pkg::spds_issue_t issue
);
    import spds_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 2);
    localparam int PW = (CW > POINT_W) ? CW : POINT_W;
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_POINTS);
    localparam logic [CW-1:0] OVER_CNT = CW'(MAX_POINTS + 1);
    localparam logic [CW-1:0] WIN_CNT  = CW'(WINDOW_LEN - 1);

    spds_state_t         state_reg;
    spds_state_t         state_next;
    logic [CW-1:0]       seen_reg;
    logic [CW-1:0]       seen_next;
    logic [ROW_W-1:0]    job_row_reg;
    logic [ROW_W-1:0]    job_row_next;
    logic [ROW_W-1:0]    job_end_reg;
    logic [ROW_W-1:0]    job_end_next;
    logic [POINT_W-1:0]  job_point_reg;
    logic [POINT_W-1:0]  job_point_next;
    logic [STATUS_W-1:0] job_status_reg;
    logic [STATUS_W-1:0] job_status_next;
    logic                job_fin_reg;
    logic                job_fin_next;

    logic          accept;
    logic          job_done;
    logic          new_job;
    logic          over;
    logic          at_max;
    logic          short_run;
    logic          first_full;
    logic [PW-1:0] point_diff;

    // decode of the incoming beat against the running count
    always_comb
    begin
        job_done   = (job_row_reg == job_end_reg) || (job_status_reg != STATUS_OK);
        accept     = in_valid && in_ready;
        over       = seen_reg > MAX_CNT;
        at_max     = seen_reg == MAX_CNT;
        short_run  = seen_reg < WIN_CNT;
        first_full = seen_reg == WIN_CNT;
        new_job    = accept && !over && (at_max || !short_run || final_sample);
        shift_en   = accept && !over && !at_max;
        point_diff = PW'(seen_reg) - PW'(WIN_CNT);
    end

    // next state
    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                state_next = new_job ? ST_ISSUE : ST_IDLE;
            end
            ST_ISSUE:
            begin
                if (adv && job_done)
                begin
                    state_next = new_job ? ST_ISSUE : ST_IDLE;
                end
                else
                begin
                    state_next = ST_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        issue.row          = job_row_reg;
        issue.meta.point   = job_point_reg;
        issue.meta.status  = job_status_reg;
        issue.meta.last    = (job_status_reg != STATUS_OK) ||
                             (job_fin_reg && (job_row_reg == ROW_LAST));
        case (state_reg)
            ST_IDLE:
            begin
                in_ready         = 1'b1;
                issue.meta.valid = 1'b0;
            end
            ST_ISSUE:
            begin
                in_ready         = adv && job_done;
                issue.meta.valid = 1'b1;
            end
            default:
            begin
                in_ready         = 1'b0;
                issue.meta.valid = 1'b0;
            end
        endcase
    end

    // job registers and sample count
    always_comb
    begin
        job_row_next    = job_row_reg;
        job_end_next    = job_end_reg;
        job_point_next  = job_point_reg;
        job_status_next = job_status_reg;
        job_fin_next    = job_fin_reg;
        seen_next       = seen_reg;

        if (new_job)
        begin
            job_fin_next = final_sample;
            job_end_next = final_sample ? ROW_LAST : ROW_CENTRE;
            job_row_next = first_full ? ROW_FIRST : ROW_CENTRE;
            if (at_max)
            begin
                job_status_next = STATUS_LONG;
                job_point_next  = '0;
            end
            else if (short_run)
            begin
                job_status_next = STATUS_SHORT;
                job_point_next  = '0;
            end
            else
            begin
                job_status_next = STATUS_OK;
                // point of row j is count - 5 + j
                job_point_next  = point_diff[POINT_W-1:0] + POINT_W'(job_row_next);
            end
        end
        else if ((state_reg == ST_ISSUE) && adv && !job_done)
        begin
            job_row_next   = job_row_reg + 3'd1;
            job_point_next = job_point_reg + 16'd1;
        end

        if (accept)
        begin
            if (final_sample)
            begin
                seen_next = '0;
            end
            else if (over)
            begin
                seen_next = seen_reg;
            end
            else if (at_max)
            begin
                seen_next = OVER_CNT;
            end
            else
            begin
                seen_next = seen_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seen_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_row_reg    <= job_row_next;
        job_end_reg    <= job_end_next;
        job_point_reg  <= job_point_next;
        job_status_reg <= job_status_next;
        job_fin_reg    <= job_fin_next;
    end

endmodule

`default_nettype wire

// File: rtl/spds_post.sv
// stencil sum, q24.24 scaling, floor and saturation, output register
`timescale 1ns / 1ps
`default_nettype none

module spds_post #(
    parameter int SW = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [SW+spds_pkg::COEF_W-1:0]  prod [spds_pkg::WINDOW_LEN],
    input  spds_pkg::spds_meta_t                   meta_in,
    input  logic signed [spds_pkg::SCALE_W-1:0]    scale,
    output logic                                   adv,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [spds_pkg::OUT_W-1:0]      derivative_value,
    output logic [spds_pkg::POINT_W-1:0]           point_number,
    output logic [spds_pkg::STATUS_W-1:0]          status,
    output logic                                   last_result
);
    import spds_pkg::*;

    localparam int PRODW  = SW + COEF_W;
    localparam int SUMW   = PRODW + 1;
    localparam int MW     = SUMW + CHUNK_W + 1;
    localparam int PRW    = SUMW + SCALE_W + 1;
    localparam int QW     = PRW - FRAC_BITS;
    localparam int NPIPE  = 5;
    localparam int NPAIR  = WINDOW_LEN / 2;
    localparam int NCHUNK = SCALE_W / CHUNK_W;

    spds_meta_t meta_reg  [NPIPE];
    spds_meta_t meta_next [NPIPE];

    logic signed [SUMW-1:0]   pair_reg  [NPAIR];
    logic signed [SUMW-1:0]   pair_next [NPAIR];
    logic signed [SUMW-1:0]   sum_reg;
    logic signed [SUMW-1:0]   sum_next;
    logic signed [CHUNK_W:0]  chunk     [NCHUNK];
    logic signed [MW-1:0]     pp_reg    [NCHUNK];
    logic signed [MW-1:0]     pp_next   [NCHUNK];
    logic signed [PRW-1:0]    lo_reg;
    logic signed [PRW-1:0]    lo_next;
    logic signed [PRW-1:0]    hi_reg;
    logic signed [PRW-1:0]    hi_next;
    logic signed [PRW-1:0]    full_reg;
    logic signed [PRW-1:0]    full_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [OUT_W-1:0]  value_reg;
    logic signed [OUT_W-1:0]  value_next;
    logic [POINT_W-1:0]       point_reg;
    logic [POINT_W-1:0]       point_next;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic                     last_reg;
    logic                     last_next;

    logic [QW-1:0]            quot;
    logic                     pos_ovf;
    logic                     neg_ovf;

    // whole pipe moves together whenever the output register is empty or its beat is taken
    assign adv = !out_valid_reg || out_ready;

    always_comb
    begin
        for (int k = 0; k < NPIPE; k++)
        begin
            if (adv)
            begin
                meta_next[k] = (k == 0) ? meta_in : meta_reg[(k == 0) ? 0 : k - 1];
            end
            else
            begin
                meta_next[k] = meta_reg[k];
            end
        end
    end

    // scale split into unsigned low chunks and a signed top chunk
    always_comb
    begin
        for (int k = 0; k < NCHUNK - 1; k++)
        begin
            chunk[k] = $signed({1'b0, scale[k*CHUNK_W +: CHUNK_W]});
        end
        chunk[NCHUNK-1] = $signed({scale[SCALE_W-1],
                                   scale[(NCHUNK-1)*CHUNK_W +: CHUNK_W]});
    end

    always_comb
    begin
        for (int k = 0; k < NPAIR; k++)
        begin
            pair_next[k] = adv ? (SUMW'(prod[2*k]) + SUMW'(prod[2*k+1])) : pair_reg[k];
        end
        sum_next = adv ? (pair_reg[0] + pair_reg[1] + pair_reg[2]) : sum_reg;
        for (int k = 0; k < NCHUNK; k++)
        begin
            pp_next[k] = adv ? (sum_reg * chunk[k]) : pp_reg[k];
        end
        lo_next   = adv ? (PRW'(pp_reg[0]) + (PRW'(pp_reg[1]) <<< CHUNK_W)) : lo_reg;
        hi_next   = adv ? (PRW'(pp_reg[2]) + (PRW'(pp_reg[3]) <<< CHUNK_W)) : hi_reg;
        full_next = adv ? (lo_reg + (hi_reg <<< (2 * CHUNK_W))) : full_reg;
    end

    // dropping the fraction bits of a two's complement word is a floor
    always_comb
    begin
        quot    = full_reg[PRW-1:FRAC_BITS];
        pos_ovf = !quot[QW-1] && (|quot[QW-2:OUT_W-1]);
        neg_ovf = quot[QW-1] && !(&quot[QW-2:OUT_W-1]);

        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        point_next     = point_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        if (adv)
        begin
            out_valid_next = meta_reg[NPIPE-1].valid;
            point_next     = meta_reg[NPIPE-1].point;
            status_next    = meta_reg[NPIPE-1].status;
            last_next      = meta_reg[NPIPE-1].last;
            if (meta_reg[NPIPE-1].status != STATUS_OK)
            begin
                value_next = '0;
            end
            else if (pos_ovf)
            begin
                value_next = 32'sh7fff_ffff;
            end
            else if (neg_ovf)
            begin
                value_next = $signed(32'h8000_0000);
            end
            else
            begin
                value_next = $signed(quot[OUT_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NPIPE; k++)
            begin
                meta_reg[k] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < NPIPE; k++)
            begin
                meta_reg[k] <= meta_next[k];
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NPAIR; k++)
        begin
            pair_reg[k] <= pair_next[k];
        end
        sum_reg <= sum_next;
        for (int k = 0; k < NCHUNK; k++)
        begin
            pp_reg[k] <= pp_next[k];
        end
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        full_reg   <= full_next;
        value_reg  <= value_next;
        point_reg  <= point_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign out_valid        = out_valid_reg;
    assign derivative_value = value_reg;
    assign point_number     = point_reg;
    assign status           = status_reg;
    assign last_result      = last_reg;

endmodule

`default_nettype wire

// File: rtl/six_point_derivative_stencil_core.sv
// top level of the six-point finite-difference derivative core
`timescale 1ns / 1ps
`default_nettype none

// Streams evenly spaced samples in, one per input beat, and returns the derivative of the
// configured order at every sample point of the data set. Six cells hold the sliding window
// and shift on each accepted sample below index MAX_POINTS; for every point to be produced
// the cells weight their samples by the stencil row of that point and a pipelined tail sums,
// scales by the signed Q24.24 output_scale, floors and saturates to 32 bits. Points are
// issued into the cell row one per cycle while the pipe is not stalled, and input is held off
// until the last row of a sample is issued: the sixth sample of a data set issues rows 0 to
// 2, a final sample rows 2 to 5 (0 to 5 if the data set is exactly six samples long), any
// later sample the centre row; throughput is set by that single issue port into the cell
// row. The whole pipe stalls while an output beat waits. A data set shorter than six samples
// gives one beat with status 1, and the sample with index MAX_POINTS gives one beat with
// status 2, after which samples are dropped up to the final one. Write configuration only
// while the block is idle. No clearing pass after reset.
module six_point_derivative_stencil_core #(
    parameter int MAX_POINTS   = 65536,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration writes
    input  logic                                  cfg_write_en,
    input  logic [spds_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [spds_pkg::SCALE_W-1:0]          cfg_data,
    // sample beats
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]        sample_value,
    input  logic                                  final_sample,
    // result beats
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [spds_pkg::OUT_W-1:0]     derivative_value,
    output logic [spds_pkg::POINT_W-1:0]          point_number,
    output logic [spds_pkg::STATUS_W-1:0]         status,
    output logic                                  last_result
);
    import spds_pkg::*;

    localparam int PRODW = SAMPLE_WIDTH + COEF_W;

    // configuration registers
    logic [ORDER_W-1:0]        order_reg;
    logic [ORDER_W-1:0]        order_next;
    logic signed [SCALE_W-1:0] scale_reg;
    logic signed [SCALE_W-1:0] scale_next;

    // stage one metadata, in step with the cell products
    spds_meta_t meta_s1_reg;
    spds_meta_t meta_s1_next;

    spds_issue_t issue;
    logic        adv;
    logic        shift_en;

    logic signed [SAMPLE_WIDTH-1:0] win  [WINDOW_LEN];
    logic signed [PRODW-1:0]        prod [WINDOW_LEN];

    always_comb
    begin
        order_next = order_reg;
        scale_next = scale_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_DERIV_ORDER:  order_next = cfg_data[ORDER_W-1:0];
                CFG_OUTPUT_SCALE: scale_next = $signed(cfg_data);
                default:          order_next = order_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 3'd1;
            scale_reg <= 48'sd139810;  // 1/120 in q24.24
        end
        else
        begin
            order_reg <= order_next;
            scale_reg <= scale_next;
        end
    end

    // counts samples and walks the rows that each sample releases
    spds_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .final_sample (final_sample),
        .adv          (adv),
        .in_ready     (in_ready),
        .shift_en     (shift_en),
        .issue        (issue)
    );

    // window row: new sample enters the top cell, older ones move down one cell per beat
    for (genvar i = 0; i < WINDOW_LEN; i++)
    begin : g_cell
        spds_cell #(
            .SW  (SAMPLE_WIDTH),
            .POS (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (shift_en),
            .sample_in  ((i == WINDOW_LEN - 1) ? sample_value
                                               : win[(i == WINDOW_LEN - 1) ? i : i + 1]),
            .sample_out (win[i]),
            .adv        (adv),
            .order      (order_reg),
            .row        (issue.row),
            .prod       (prod[i])
        );
    end

    always_comb
    begin
        meta_s1_next = adv ? issue.meta : meta_s1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_s1_reg <= '0;
        end
        else
        begin
            meta_s1_reg <= meta_s1_next;
        end
    end

    // sum, scale, floor, saturate and hold the result beat
    spds_post #(
        .SW (SAMPLE_WIDTH)
    ) u_post (
        .clk              (clk),
        .rst_n            (rst_n),
        .prod             (prod),
        .meta_in          (meta_s1_reg),
        .scale            (scale_reg),
        .adv              (adv),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .derivative_value (derivative_value),
        .point_number     (point_number),
        .status           (status),
        .last_result      (last_result)
    );

    // a new sample may only shift the window once the last row of the old one is issued
    a_shift_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && issue.meta.valid) |-> adv)
        else $error("window shifted while rows of the previous sample were pending");

    // only the six stencil rows are ever issued
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        issue.meta.valid |-> (issue.row <= ROW_LAST))
        else $error("stencil row out of range");

    // error beats carry a zero value, point zero and close the data set
    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_OK)) |->
            ((derivative_value == '0) && (point_number == '0) && last_result))
        else $error("malformed error beat");

endmodule

`default_nettype wire
